// File: hdl/sfb_pkg.sv
// shared types and constants for the serpentine led framebuffer
package sfb_pkg;

    localparam int COLOUR_W    = 24;
    localparam int COORD_W     = 7;
    localparam int BOARD_REG_W = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int WORK_W      = 8;
    localparam int IDX_W       = 13;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_MOVE  = 2'd2,
        OP_DRAW  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BOARD_WIDTH   = 2'd0,
        REG_BOARD_HEIGHT  = 2'd1,
        REG_COLUMN_WIRING = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_FIRST,
        F_SECOND
    } front_state_t;

    typedef struct packed {
        logic mem_en;
        logic write_en;
        logic emit;
        logic in_bounds;
    } sfb_ctl_t;

    localparam int CTL_W = $bits(sfb_ctl_t);

endpackage

// File: hdl/sfb_front.sv
// front end: config registers, cursor, coordinate mapping and command issue
module sfb_front
    import sfb_pkg::*;
#(
    parameter int MAX_SIDE    = 32,
    parameter int PIXEL_COUNT = 1024,
    parameter int CUR_W       = 5,
    parameter int ADDR_W      = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BOARD_REG_W-1:0] cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             opcode,
    input  logic [COORD_W-1:0]     coord_x,
    input  logic [COORD_W-1:0]     coord_y,
    input  logic [COLOUR_W-1:0]    pixel_colour,
    input  logic                   clear_busy,
    output logic                   cmd_valid,
    input  logic                   cmd_ready,
    output sfb_ctl_t               cmd_ctl,
    output logic [ADDR_W-1:0]      cmd_addr,
    output logic [COLOUR_W-1:0]    cmd_colour,
    output logic [CUR_W-1:0]       cmd_col,
    output logic [CUR_W-1:0]       cmd_row
);

    localparam logic [WORK_W-1:0] MAX_SIDE_V  = WORK_W'(MAX_SIDE);
    localparam logic [IDX_W-1:0]  PIX_LIMIT_V = IDX_W'(PIXEL_COUNT);

    front_state_t           state_reg, state_next;
    logic [BOARD_REG_W-1:0] width_reg, height_reg;
    logic                   wiring_reg;
    opcode_t                op_reg;
    logic [COORD_W-1:0]     x_reg, y_reg;
    logic [COLOUR_W-1:0]    colour_reg;
    logic [CUR_W-1:0]       cursor_col_reg, cursor_col_next;
    logic [CUR_W-1:0]       cursor_row_reg, cursor_row_next;

    logic signed [WORK_W-1:0] side_w, side_h;
    logic signed [WORK_W-1:0] cur_x, cur_y, step_x, step_y;
    logic signed [WORK_W-1:0] map_x, map_y;
    logic signed [WORK_W-1:0] sum_x, sum_y;
    logic [CUR_W-1:0]         new_col, new_row;
    logic                     pixel_op;
    logic                     map_ok;
    logic [IDX_W-1:0]         map_idx;
    logic                     in_side;
    logic [WORK_W-1:0]        along;
    logic [WORK_W-1:0]        major;
    logic [WORK_W-1:0]        span;
    logic [2*WORK_W-1:0]      prod;
    logic [IDX_W-1:0]         lin_idx;

    function automatic logic signed [WORK_W-1:0] eff_side(input logic [BOARD_REG_W-1:0] r);
        logic [WORK_W-1:0] v;
        v = WORK_W'(r);
        if (r == '0)
            return WORK_W'(1);
        else if (v > MAX_SIDE_V)
            return MAX_SIDE_V;
        else
            return v;
    endfunction

    function automatic logic [CUR_W-1:0] clamp_axis(input logic signed [WORK_W-1:0] s,
                                                    input logic signed [WORK_W-1:0] side);
        logic signed [WORK_W-1:0] top;
        top = side - WORK_W'(1);
        if (s >= side)
            return top[CUR_W-1:0];
        else if (s < 0)
            return '0;
        else
            return s[CUR_W-1:0];
    endfunction

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= BOARD_REG_W'(16);
            height_reg <= BOARD_REG_W'(16);
            wiring_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BOARD_WIDTH:   width_reg  <= cfg_data;
                REG_BOARD_HEIGHT:  height_reg <= cfg_data;
                REG_COLUMN_WIRING: wiring_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg     <= opcode_t'(opcode);
            x_reg      <= coord_x;
            y_reg      <= coord_y;
            colour_reg <= pixel_colour;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
        end
    end

    // cursor stepping and coordinate mapping
    always_comb
    begin
        side_w   = eff_side(width_reg);
        side_h   = eff_side(height_reg);
        cur_x    = signed'(WORK_W'(cursor_col_reg));
        cur_y    = signed'(WORK_W'(cursor_row_reg));
        step_x   = WORK_W'(signed'(x_reg));
        step_y   = WORK_W'(signed'(y_reg));
        sum_x    = cur_x + step_x;
        sum_y    = cur_y + step_y;
        new_col  = clamp_axis(sum_x, side_w);
        new_row  = clamp_axis(sum_y, side_h);
        pixel_op = (op_reg == OP_WRITE) || (op_reg == OP_READ);

        if (state_reg == F_FIRST && pixel_op)
        begin
            map_x = step_x;
            map_y = step_y;
        end
        else
        begin
            map_x = cur_x;
            map_y = cur_y;
        end

        in_side = (map_x >= 0) && (map_y >= 0) && (map_x < side_w) && (map_y < side_h);
        if (wiring_reg)
        begin
            along = map_x[0] ? WORK_W'(side_h - map_y - WORK_W'(1)) : WORK_W'(map_y);
            major = map_x;
            span  = side_h;
        end
        else
        begin
            along = map_y[0] ? WORK_W'(side_w - map_x - WORK_W'(1)) : WORK_W'(map_x);
            major = map_y;
            span  = side_w;
        end
        prod    = major * span;
        lin_idx = prod[IDX_W-1:0] + IDX_W'(along);
        map_idx = lin_idx;
        map_ok  = in_side && (lin_idx < PIX_LIMIT_V);
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        in_ready        = 1'b0;
        cmd_valid       = 1'b0;
        cmd_ctl         = '0;
        cmd_addr        = map_idx[ADDR_W-1:0];
        cmd_colour      = colour_reg;
        cmd_col         = cursor_col_reg;
        cmd_row         = cursor_row_reg;

        unique case (state_reg)
            F_IDLE:
            begin
                in_ready = !clear_busy;
                if (in_valid && !clear_busy)
                    state_next = F_FIRST;
            end
            F_FIRST:
            begin
                cmd_valid = 1'b1;
                unique case (op_reg)
                    OP_WRITE: cmd_ctl = '{mem_en: map_ok, write_en: 1'b1, emit: 1'b1,
                                          in_bounds: map_ok};
                    OP_READ:  cmd_ctl = '{mem_en: map_ok, write_en: 1'b0, emit: 1'b1,
                                          in_bounds: map_ok};
                    OP_MOVE:
                    begin
                        cmd_ctl = '{mem_en: 1'b0, write_en: 1'b0, emit: 1'b1, in_bounds: 1'b0};
                        cmd_col = new_col;
                        cmd_row = new_row;
                    end
                    OP_DRAW:
                    begin
                        // clear the old cursor pixel first
                        cmd_ctl    = '{mem_en: map_ok, write_en: 1'b1, emit: 1'b0,
                                       in_bounds: 1'b0};
                        cmd_colour = '0;
                    end
                    default: ;
                endcase
                if (cmd_ready)
                begin
                    if (!pixel_op)
                    begin
                        cursor_col_next = new_col;
                        cursor_row_next = new_row;
                    end
                    state_next = (op_reg == OP_DRAW) ? F_SECOND : F_IDLE;
                end
            end
            F_SECOND:
            begin
                cmd_valid = 1'b1;
                cmd_ctl   = '{mem_en: map_ok, write_en: 1'b1, emit: 1'b1, in_bounds: map_ok};
                if (cmd_ready)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

endmodule

// File: hdl/sfb_queue.sv
// short command queue between front and back
module sfb_queue
    import sfb_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: hdl/sfb_back.sv
// back end: pixel store, clearing pass and result register
module sfb_back
    import sfb_pkg::*;
#(
    parameter int PIXEL_COUNT = 1024,
    parameter int CUR_W       = 5,
    parameter int ADDR_W      = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  sfb_ctl_t            cmd_ctl,
    input  logic [ADDR_W-1:0]   cmd_addr,
    input  logic [COLOUR_W-1:0] cmd_colour,
    input  logic [CUR_W-1:0]    cmd_col,
    input  logic [CUR_W-1:0]    cmd_row,
    output logic                clear_busy,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COLOUR_W-1:0] read_colour,
    output logic [CUR_W-1:0]    cursor_col,
    output logic [CUR_W-1:0]    cursor_row,
    output logic                in_bounds
);

    logic [COLOUR_W-1:0] store [PIXEL_COUNT];
    logic [COLOUR_W-1:0] rdata_reg;

    logic                clearing_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;

    logic                s1_valid_reg;
    logic                s1_emit_reg;
    logic                s1_read_reg;
    logic                s1_bounds_reg;
    logic [CUR_W-1:0]    s1_col_reg, s1_row_reg;

    logic                out_valid_reg;
    logic [COLOUR_W-1:0] out_colour_reg;
    logic [CUR_W-1:0]    out_col_reg, out_row_reg;
    logic                out_bounds_reg;

    logic                s1_adv, pop, to_out;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_addr;
    logic [COLOUR_W-1:0] mem_wdata;

    assign s1_adv    = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || out_ready);
    assign to_out    = s1_adv && s1_emit_reg;
    assign cmd_ready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign pop       = cmd_valid && cmd_ready;

    assign mem_we    = clearing_reg || (pop && cmd_ctl.mem_en && cmd_ctl.write_en);
    assign mem_addr  = clearing_reg ? clr_addr_reg : cmd_addr;
    assign mem_wdata = clearing_reg ? '0 : cmd_colour;

    assign clear_busy  = clearing_reg;
    assign out_valid   = out_valid_reg;
    assign read_colour = out_colour_reg;
    assign cursor_col  = out_col_reg;
    assign cursor_row  = out_row_reg;
    assign in_bounds   = out_bounds_reg;

    // read data is held while the result waits in the stage
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store[mem_addr] <= mem_wdata;
        if (pop)
            rdata_reg <= store[mem_addr];
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == ADDR_W'(PIXEL_COUNT - 1))
                clearing_reg <= 1'b0;
            else
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_emit_reg   <= cmd_ctl.emit;
            s1_read_reg   <= cmd_ctl.mem_en && !cmd_ctl.write_en;
            s1_bounds_reg <= cmd_ctl.in_bounds;
            s1_col_reg    <= cmd_col;
            s1_row_reg    <= cmd_row;
        end
        if (to_out)
        begin
            out_colour_reg <= s1_read_reg ? rdata_reg : '0;
            out_col_reg    <= s1_col_reg;
            out_row_reg    <= s1_row_reg;
            out_bounds_reg <= s1_bounds_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (to_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// File: hdl/serpentine_led_framebuffer.sv
// top level of the serpentine led framebuffer
//
//   channel   signals                                            direction
//   input     in_valid/in_ready, opcode, coord_x/y, pixel_colour  in
//   result    out_valid/out_ready, read_colour, cursor_col/row,   out
//             in_bounds
//   config    cfg_write, cfg_index, cfg_data                       in
//
// a write, read or plain move issues one command from the front end, a drawing move two,
// because the pixel store has a single port (clear old pixel, then paint new one)
// results pass from the store through the s1 stage into the output register
// after reset a clearing pass zeroes every address of the store, with in_ready low
// a stalled result holds the back end; the two-entry queue lets the front issue up to two more commands
module serpentine_led_framebuffer
    import sfb_pkg::*;
#(
    parameter int MAX_SIDE    = 32,
    parameter int PIXEL_COUNT = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [BOARD_REG_W-1:0]         cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     opcode,
    input  logic [COORD_W-1:0]             coord_x,
    input  logic [COORD_W-1:0]             coord_y,
    input  logic [COLOUR_W-1:0]            pixel_colour,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [COLOUR_W-1:0]            read_colour,
    output logic [$clog2(MAX_SIDE)-1:0]    cursor_col,
    output logic [$clog2(MAX_SIDE)-1:0]    cursor_row,
    output logic                           in_bounds
);

    localparam int CUR_W  = $clog2(MAX_SIDE);
    localparam int ADDR_W = $clog2(PIXEL_COUNT);
    localparam int Q_W    = CTL_W + ADDR_W + COLOUR_W + 2 * CUR_W;

    logic                clear_busy;
    logic                f_valid, f_ready;
    sfb_ctl_t            f_ctl;
    logic [ADDR_W-1:0]   f_addr;
    logic [COLOUR_W-1:0] f_colour;
    logic [CUR_W-1:0]    f_col, f_row;

    logic                b_valid, b_ready;
    logic [Q_W-1:0]      b_data;
    sfb_ctl_t            b_ctl;
    logic [ADDR_W-1:0]   b_addr;
    logic [COLOUR_W-1:0] b_colour;
    logic [CUR_W-1:0]    b_col, b_row;

    assign {b_ctl, b_addr, b_colour, b_col, b_row} = b_data;

    sfb_front #(
        .MAX_SIDE    (MAX_SIDE),
        .PIXEL_COUNT (PIXEL_COUNT),
        .CUR_W       (CUR_W),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .pixel_colour (pixel_colour),
        .clear_busy   (clear_busy),
        .cmd_valid    (f_valid),
        .cmd_ready    (f_ready),
        .cmd_ctl      (f_ctl),
        .cmd_addr     (f_addr),
        .cmd_colour   (f_colour),
        .cmd_col      (f_col),
        .cmd_row      (f_row)
    );

    sfb_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_ctl, f_addr, f_colour, f_col, f_row}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    sfb_back #(
        .PIXEL_COUNT (PIXEL_COUNT),
        .CUR_W       (CUR_W),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (b_valid),
        .cmd_ready   (b_ready),
        .cmd_ctl     (b_ctl),
        .cmd_addr    (b_addr),
        .cmd_colour  (b_colour),
        .cmd_col     (b_col),
        .cmd_row     (b_row),
        .clear_busy  (clear_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_colour (read_colour),
        .cursor_col  (cursor_col),
        .cursor_row  (cursor_row),
        .in_bounds   (in_bounds)
    );

endmodule
